@@ rtl/core/dmcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dmcd_pkg
// Types shared by the direct-mapped cache directory: request and result
// payloads and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dmcd_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFFSET_W = 5;
  localparam int unsigned BLOCK_W  = 27;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned TAG_W    = 20;
  localparam int unsigned COUNT_W  = 32;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              is_write;
  } in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [BLOCK_W-1:0]  block_number;
    logic [INDEX_W-1:0]  line_index;
    logic [TAG_W-1:0]    tag_value;
    logic                miss;
    logic                mem_read;
    logic                mem_write;
    logic                replacement;
    logic [TAG_W-1:0]    evicted_tag;
    logic [COUNT_W-1:0]  hit_total;
    logic [COUNT_W-1:0]  miss_total;
    logic [COUNT_W-1:0]  write_total;
  } out_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/dmcd_dpath.sv @@
// ----------------------------------------------------------------------------
// dmcd_dpath
// Request register, tag ram with registered read, hit check, counters and
// the result register of the cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

module dmcd_dpath #(
  parameter int unsigned NUM_LINES   = 128,
  parameter int unsigned OFFSET_BITS = 5
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dmcd_pkg::cmd_t cmd,
  output dmcd_pkg::sts_t      sts,
  input  wire dmcd_pkg::in_t  in_data,
  output dmcd_pkg::out_t      out_data
);

  localparam int unsigned IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int unsigned BLK_W = dmcd_pkg::ADDR_W - OFFSET_BITS;
  localparam int unsigned TAG_W = BLK_W - IDX_W;

  logic [TAG_W:0]   mem [NUM_LINES];
  logic [TAG_W:0]   rd_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic [IDX_W-1:0] clr_cnt_nxt;
  dmcd_pkg::in_t    req_r;
  dmcd_pkg::out_t   out_r;
  dmcd_pkg::out_t   out_nxt;

  logic [dmcd_pkg::COUNT_W-1:0] hit_cnt_r;
  logic [dmcd_pkg::COUNT_W-1:0] hit_cnt_nxt;
  logic [dmcd_pkg::COUNT_W-1:0] miss_cnt_r;
  logic [dmcd_pkg::COUNT_W-1:0] miss_cnt_nxt;
  logic [dmcd_pkg::COUNT_W-1:0] wr_cnt_r;
  logic [dmcd_pkg::COUNT_W-1:0] wr_cnt_nxt;

  logic [IDX_W-1:0]       in_idx;
  logic [OFFSET_BITS-1:0] offset;
  logic [BLK_W-1:0]       block;
  logic [IDX_W-1:0]       idx;
  logic [TAG_W-1:0]       tag;
  logic                   hit;
  logic                   fill;

  assign in_idx = in_data.address[OFFSET_BITS +: IDX_W];
  assign offset = req_r.address[OFFSET_BITS-1:0];
  assign block  = req_r.address[dmcd_pkg::ADDR_W-1:OFFSET_BITS];
  assign idx    = block[IDX_W-1:0];
  assign tag    = block[BLK_W-1:IDX_W];
  assign hit    = rd_r[TAG_W] && (rd_r[TAG_W-1:0] == tag);
  assign fill   = cmd.commit && !hit && !req_r.is_write;

  assign sts.clr_last = (clr_cnt_r == IDX_W'(NUM_LINES - 1));
  assign clr_cnt_nxt  = clr_cnt_r + IDX_W'(1);

  // tag ram: clearing pass, fill on read miss, one registered read per request
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt_r] <= '0;
    end else if (fill) begin
      mem[idx] <= {1'b1, tag};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r + dmcd_pkg::COUNT_W'(hit);
    miss_cnt_nxt = miss_cnt_r + dmcd_pkg::COUNT_W'(!hit);
    wr_cnt_nxt   = wr_cnt_r + dmcd_pkg::COUNT_W'(req_r.is_write);

    out_nxt              = '0;
    out_nxt.byte_offset  = dmcd_pkg::OFFSET_W'(offset);
    out_nxt.block_number = dmcd_pkg::BLOCK_W'(block);
    out_nxt.line_index   = dmcd_pkg::INDEX_W'(idx);
    out_nxt.tag_value    = dmcd_pkg::TAG_W'(tag);
    out_nxt.miss         = !hit;
    out_nxt.mem_read     = !hit && !req_r.is_write;
    out_nxt.mem_write    = req_r.is_write;
    out_nxt.replacement  = !hit && !req_r.is_write && rd_r[TAG_W];
    out_nxt.evicted_tag  = (!hit && !req_r.is_write && rd_r[TAG_W]) ?
                           dmcd_pkg::TAG_W'(rd_r[TAG_W-1:0]) : '0;
    out_nxt.hit_total    = hit_cnt_nxt;
    out_nxt.miss_total   = miss_cnt_nxt;
    out_nxt.write_total  = wr_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      wr_cnt_r   <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_nxt;
      end
      if (cmd.commit) begin
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
        wr_cnt_r   <= wr_cnt_nxt;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ rtl/core/dmcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmcd_ctrl
// Sequencer of the cache directory: clearing pass, request accept, tag check
// and commit, and the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmcd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dmcd_pkg::cmd_t      cmd,
  input  wire dmcd_pkg::sts_t sts
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || !out_stall;
  assign cmd.clr_en = (state_r == ST_CLEAR);
  assign cmd.accept = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit = (state_r == ST_CHECK) && out_free;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.commit)
    else $error("result overwritten while stalled");

  // every accepted request is checked before the next one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_CHECK) && !cmd.accept)
    else $error("second request taken before commit");

  // clearing pass ends only on the last line
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !sts.clr_last) |=> (state_r == ST_CLEAR))
    else $error("clearing pass cut short");

  // a commit always leaves a result waiting
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit lost its result");

endmodule

`default_nettype wire

@@ rtl/core/direct_mapped_cache_directory.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_cache_directory
// Tag directory of a direct-mapped, write-through, no-write-allocate cache.
// ----------------------------------------------------------------------------
// For each request, the accept edge reads the line's valid bit and tag from
// the single-port tag ram into a register, and the commit edge compares the
// tag, fills the line on a read miss, updates the hit, miss and write
// counters and loads the result register. A new request is taken once the
// previous one has committed; the result register holds one result while the
// next request is looked up, so a stalled result costs throughput only when a
// second result is ready behind it. After reset a clearing pass
// invalidates every line, during which in_stall stays high. NUM_LINES
// must be a power of two.
`default_nettype none

module direct_mapped_cache_directory #(
  parameter int unsigned NUM_LINES   = 128,
  parameter int unsigned OFFSET_BITS = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire dmcd_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output dmcd_pkg::out_t     out_data
);

  dmcd_pkg::cmd_t cmd;
  dmcd_pkg::sts_t sts;

  dmcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dmcd_dpath #(
    .NUM_LINES   (NUM_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ tb/tb_direct_mapped_cache_directory.sv @@
// ----------------------------------------------------------------------------
// tb_direct_mapped_cache_directory
// Self-checking bench for the direct-mapped cache directory. A scoreboard
// keeps its own copy of the valid bits, tags and counters, predicts each
// result when a request transfer is taken, and compares every result
// transfer field by field in order. Directed references cover cold misses,
// hits, write-through, write misses without allocation and replacements.
// They are followed by random references drawn mostly from a small pool of
// tags, so that lines hit and get replaced often. The sender runs in bursts
// and the receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

class access_scoreboard;
  localparam int unsigned LINES       = 1 << dmcd_pkg::INDEX_W;
  localparam int unsigned MAX_REPORTS = 10;

  bit                           line_ok   [LINES];
  logic [dmcd_pkg::TAG_W-1:0]   line_tag  [LINES];
  logic [dmcd_pkg::COUNT_W-1:0] hits;
  logic [dmcd_pkg::COUNT_W-1:0] misses;
  logic [dmcd_pkg::COUNT_W-1:0] writes;
  dmcd_pkg::out_t               expected_q[$];
  int unsigned                  errors;
  int unsigned                  checked;
  int unsigned                  replaced;
  int unsigned                  write_misses;

  function new();
    foreach (line_ok[i]) begin
      line_ok[i]  = 1'b0;
      line_tag[i] = '0;
    end
    hits         = '0;
    misses       = '0;
    writes       = '0;
    errors       = 0;
    checked      = 0;
    replaced     = 0;
    write_misses = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void note_access(dmcd_pkg::in_t req);
    dmcd_pkg::out_t               r;
    logic [dmcd_pkg::BLOCK_W-1:0] blk;
    logic [dmcd_pkg::INDEX_W-1:0] idx;
    logic [dmcd_pkg::TAG_W-1:0]   tg;
    blk = req.address[dmcd_pkg::ADDR_W-1:dmcd_pkg::OFFSET_W];
    idx = blk[dmcd_pkg::INDEX_W-1:0];
    tg  = blk[dmcd_pkg::BLOCK_W-1:dmcd_pkg::INDEX_W];
    r = '0;
    r.byte_offset  = req.address[dmcd_pkg::OFFSET_W-1:0];
    r.block_number = blk;
    r.line_index   = idx;
    r.tag_value    = tg;
    if (line_ok[idx] && line_tag[idx] == tg) begin
      hits = hits + dmcd_pkg::COUNT_W'(1);
    end else begin
      r.miss = 1'b1;
      misses = misses + dmcd_pkg::COUNT_W'(1);
      if (req.is_write) begin
        write_misses++;
      end else begin
        r.mem_read = 1'b1;
        if (line_ok[idx]) begin
          r.replacement = 1'b1;
          r.evicted_tag = line_tag[idx];
          replaced++;
        end
        line_ok[idx]  = 1'b1;
        line_tag[idx] = tg;
      end
    end
    if (req.is_write) begin
      r.mem_write = 1'b1;
      writes = writes + dmcd_pkg::COUNT_W'(1);
    end
    r.hit_total   = hits;
    r.miss_total  = misses;
    r.write_total = writes;
    expected_q.push_back(r);
  endfunction

  function bit field_differs(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v === exp_v) return 1'b0;
    if (errors < MAX_REPORTS)
      $display("mismatch in result %0d, %s: expected 0x%0h actual 0x%0h",
               checked, name, exp_v, act_v);
    return 1'b1;
  endfunction

  function void check_result(dmcd_pkg::out_t got);
    dmcd_pkg::out_t exp_r;
    bit             bad;
    if (expected_q.size() == 0) begin
      if (errors < MAX_REPORTS)
        $display("result transfer with nothing expected: 0x%0h", got);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    checked++;
    bad = 1'b0;
    bad |= field_differs("byte_offset", 32'(exp_r.byte_offset), 32'(got.byte_offset));
    bad |= field_differs("block_number", 32'(exp_r.block_number),
                         32'(got.block_number));
    bad |= field_differs("line_index", 32'(exp_r.line_index), 32'(got.line_index));
    bad |= field_differs("tag_value", 32'(exp_r.tag_value), 32'(got.tag_value));
    bad |= field_differs("miss", 32'(exp_r.miss), 32'(got.miss));
    bad |= field_differs("mem_read", 32'(exp_r.mem_read), 32'(got.mem_read));
    bad |= field_differs("mem_write", 32'(exp_r.mem_write), 32'(got.mem_write));
    bad |= field_differs("replacement", 32'(exp_r.replacement), 32'(got.replacement));
    bad |= field_differs("evicted_tag", 32'(exp_r.evicted_tag), 32'(got.evicted_tag));
    bad |= field_differs("hit_total", exp_r.hit_total, got.hit_total);
    bad |= field_differs("miss_total", exp_r.miss_total, got.miss_total);
    bad |= field_differs("write_total", exp_r.write_total, got.write_total);
    if (bad) errors++;
  endfunction
endclass

module tb_direct_mapped_cache_directory;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned POOL_SIZE    = 4;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  dmcd_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  dmcd_pkg::out_t out_data;

  access_scoreboard           sb;
  bit                         hold_request = 1'b0;
  bit                         run_over     = 1'b0;
  logic [dmcd_pkg::TAG_W-1:0] tag_pool [POOL_SIZE];

  direct_mapped_cache_directory u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout, %0d results still outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0) sb.note_access(in_data);
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
  end

  task automatic send_access(input logic [dmcd_pkg::ADDR_W-1:0] addr, input logic wr);
    in_valid <= 1'b1;
    in_data  <= '{address: addr, is_write: wr};
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic dmcd_pkg::in_t random_access();
    dmcd_pkg::in_t                r;
    logic [dmcd_pkg::INDEX_W-1:0] idx;
    r.address  = $urandom;
    r.is_write = ($urandom_range(0, 9) < 3);
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1) == 0) begin
        idx = dmcd_pkg::INDEX_W'($urandom_range(0, 7));
      end else begin
        idx = dmcd_pkg::INDEX_W'($urandom);
      end
      r.address[dmcd_pkg::ADDR_W-1:dmcd_pkg::OFFSET_W+dmcd_pkg::INDEX_W] =
        tag_pool[$urandom_range(0, POOL_SIZE-1)];
      r.address[dmcd_pkg::OFFSET_W+dmcd_pkg::INDEX_W-1:dmcd_pkg::OFFSET_W] = idx;
    end
    return r;
  endfunction

  // receiver: spans of no stall, light, medium and heavy stalling
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    @(posedge clk);
    while (!run_over) begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 40);
      repeat (span) begin
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            out_stall <= ($urandom_range(0, 9) != 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned   sent;
    int unsigned   burst;
    dmcd_pkg::in_t req;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // cold miss, hit at top offset, write hit
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_001F, 1'b0);
    send_access(32'h0000_0004, 1'b1);
    // all-ones address, hit, then replacement on the top line
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'hFFFF_FFE0, 1'b0);
    send_access(32'h7FFF_FFFF, 1'b0);
    // write miss on an invalid line does not allocate
    send_access(32'h1234_5678, 1'b1);
    send_access(32'h1234_5678, 1'b0);
    send_access(32'h1234_5678, 1'b1);
    // write miss on a valid line with another tag leaves the line alone
    send_access(32'hABCD_E678, 1'b1);
    send_access(32'h1234_5670, 1'b0);
    send_access(32'hABCD_E660, 1'b0);
    // back-to-back references to one line, then to two other lines
    send_access(32'h0000_1000, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_0010, 1'b0);
    send_access(32'h0000_0008, 1'b1);
    send_access(32'hAAAA_AAAA, 1'b0);
    send_access(32'h5555_5555, 1'b1);
    send_access(32'h5555_5555, 1'b0);
    send_access(32'hAAAA_AAAA, 1'b1);
    sender_gap(3);

    foreach (tag_pool[i]) tag_pool[i] = dmcd_pkg::TAG_W'($urandom);
    hold_request = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        req = random_access();
        send_access(req.address, req.is_write);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_over = 1'b1;

    $display("checked %0d references: %0d hits, %0d misses, %0d memory writes",
             sb.checked, sb.hits, sb.misses, sb.writes);
    $display("%0d replacements, %0d write misses, %0d mismatching results",
             sb.replaced, sb.write_misses, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire
